### rtl/pbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbd_pkg;

    // width of the debounce countdown
    localparam int TIMER_WIDTH = 20;

    localparam int TICKS_WIDTH = 20;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 20;

    localparam int S_TDATA_WIDTH = 8;
    localparam int M_TDATA_WIDTH = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACTIVE_HIGH    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IGNORE_LID     = 2'd2;

    localparam logic [TICKS_WIDTH-1:0] DEBOUNCE_TICKS_RESET = 20'd30000;

    typedef struct packed {
        logic [TICKS_WIDTH-1:0] debounce_ticks;
        logic                   active_high;
        logic                   ignore_lid;
    } cfg_t;

    typedef struct packed {
        logic pin_level;
        logic lid_open;
        logic simulate_press;
        logic force_evaluate;
    } tick_t;

    typedef struct packed {
        logic pressed;
        logic scan_disabled;
        logic change_pulse;
        logic host_press_pulse;
        logic debouncing;
    } result_t;

endpackage

`default_nettype wire

### rtl/pbd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module pbd_cfg
    import pbd_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output cfg_t                            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_DEBOUNCE_TICKS: cfg_next.debounce_ticks = cfg_data[TICKS_WIDTH-1:0];
                CFG_ACTIVE_HIGH:    cfg_next.active_high = cfg_data[0];
                CFG_IGNORE_LID:     cfg_next.ignore_lid = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= DEBOUNCE_TICKS_RESET;
            cfg_reg.active_high <= 1'b0;
            cfg_reg.ignore_lid <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/pbd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module pbd_core
    import pbd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic advance,
    input  tick_t     tick,
    input  cfg_t      cfg,
    output result_t   result
);

    localparam int CMP_WIDTH = (TIMER_WIDTH > TICKS_WIDTH) ? TIMER_WIDTH : TICKS_WIDTH;
    localparam logic [TIMER_WIDTH-1:0] TMR_MAX = {TIMER_WIDTH{1'b1}};

    logic                   debounced_reg, debounced_next;
    logic [TIMER_WIDTH-1:0] countdown_reg, countdown_next;
    logic                   counting_reg, counting_next;
    logic                   last_pin_reg, last_pin_next;
    logic                   scan_hold_reg, scan_hold_next;
    logic                   init_reg, init_next;

    logic                   raw;
    logic                   sample;
    logic                   change;
    logic [TIMER_WIDTH-1:0] load_value;

    // narrow timers saturate the configured tick count
    always_comb begin
        if (CMP_WIDTH'(cfg.debounce_ticks) > CMP_WIDTH'(TMR_MAX)) begin
            load_value = TMR_MAX;
        end else begin
            load_value = TIMER_WIDTH'(cfg.debounce_ticks);
        end
    end

    always_comb begin
        if (tick.simulate_press) begin
            raw = 1'b1;
        end else if (!tick.lid_open && !cfg.ignore_lid) begin
            raw = 1'b0;
        end else begin
            raw = (tick.pin_level == cfg.active_high);
        end
    end

    always_comb begin
        debounced_next = debounced_reg;
        countdown_next = countdown_reg;
        counting_next = counting_reg;
        last_pin_next = last_pin_reg;
        scan_hold_next = scan_hold_reg;
        init_next = 1'b1;
        sample = 1'b0;
        change = 1'b0;

        if (!init_reg) begin
            debounced_next = raw;
            last_pin_next = tick.pin_level;
        end else if (tick.pin_level != last_pin_reg) begin
            last_pin_next = tick.pin_level;
            if (raw) begin
                scan_hold_next = 1'b1;
            end
            countdown_next = load_value;
            counting_next = (load_value != '0);
            sample = (load_value == '0);
        end else if (counting_reg) begin
            countdown_next = countdown_reg - TIMER_WIDTH'(1);
            if (countdown_reg == TIMER_WIDTH'(1)) begin
                counting_next = 1'b0;
                sample = 1'b1;
            end
        end

        if (tick.force_evaluate) begin
            sample = 1'b1;
        end

        if (sample) begin
            if (!raw) begin
                scan_hold_next = 1'b0;
            end
            if (raw != debounced_next) begin
                debounced_next = raw;
                change = 1'b1;
            end
        end

        result.pressed = debounced_next;
        result.scan_disabled = scan_hold_next;
        result.change_pulse = change;
        result.host_press_pulse = change & raw;
        result.debouncing = counting_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounced_reg <= 1'b0;
            countdown_reg <= '0;
            counting_reg <= 1'b0;
            last_pin_reg <= 1'b0;
            scan_hold_reg <= 1'b0;
            init_reg <= 1'b0;
        end else if (advance) begin
            debounced_reg <= debounced_next;
            countdown_reg <= countdown_next;
            counting_reg <= counting_next;
            last_pin_reg <= last_pin_next;
            scan_hold_reg <= scan_hold_next;
            init_reg <= init_next;
        end
    end

endmodule

`default_nettype wire

### rtl/power_button_debouncer.sv
`timescale 1ns / 1ps
`default_nettype none

// Power button debouncer. Each input beat is one tick of the button sampler and
// yields exactly one result beat. A tick is taken every clock while the result
// register is empty or being drained, so the block runs at one tick per cycle;
// the state update and the result are computed in the same cycle the tick is
// accepted and the result is registered onto m_ in the next cycle. Every pin edge reloads
// the debounce countdown from debounce_ticks, and the raw level is sampled when
// the countdown reaches zero or when force_evaluate is set. Configuration
// (cfg_index 0: debounce_ticks, 1: active_high, 2: ignore_lid) is always ready
// and should be written while no ticks are in flight.
module power_button_debouncer
    import pbd_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // [0] pin_level, [1] lid_open, [2] simulate_press, [3] force_evaluate
    input  wire logic [S_TDATA_WIDTH-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [0] pressed, [1] scan_disabled, [2] change_pulse, [3] host_press_pulse,
    // [4] debouncing
    output logic [M_TDATA_WIDTH-1:0]        m_tdata,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_t    cfg;
    tick_t   tick;
    result_t result;
    logic    accept;

    result_t out_reg;
    logic    out_valid_reg;

    assign tick.pin_level = s_tdata[0];
    assign tick.lid_open = s_tdata[1];
    assign tick.simulate_press = s_tdata[2];
    assign tick.force_evaluate = s_tdata[3];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;

    pbd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (accept),
        .tick    (tick),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {3'b000, out_reg.debouncing, out_reg.host_press_pulse,
                      out_reg.change_pulse, out_reg.scan_disabled, out_reg.pressed};

    // a host press event is always a change to pressed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.host_press_pulse |-> out_reg.change_pulse && out_reg.pressed)
        else $error("host press without change to pressed");

    // a debounced release always drops the scan hold
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.change_pulse && !out_reg.pressed |-> !out_reg.scan_disabled)
        else $error("scan hold kept after debounced release");

    // a waiting result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !accept)
        else $error("tick accepted over a stalled result");

    // every accepted tick produces a result beat on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("result beat missing after accepted tick");

endmodule

`default_nettype wire

### bench/pbd_checker.sv
`timescale 1ns / 1ps

module pbd_checker
    import pbd_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    input  wire logic                       s_tready,
    input  wire logic [S_TDATA_WIDTH-1:0]   s_tdata,
    input  wire logic                       m_tvalid,
    input  wire logic                       m_tready,
    input  wire logic [M_TDATA_WIDTH-1:0]   m_tdata,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                              errors,
    output int                              pending,
    output int                              changes,
    output int                              presses
);

    cfg_t                   regs;
    logic                   debounced;
    logic                   counting;
    logic                   last_pin;
    logic                   scan_hold;
    logic                   started;
    logic [TIMER_WIDTH-1:0] countdown;
    result_t                status_due[$];
    int                     err_n;
    int                     chg_n;
    int                     prs_n;

    initial begin
        errors = 0;
        pending = 0;
        changes = 0;
        presses = 0;
        err_n = 0;
        chg_n = 0;
        prs_n = 0;
    end

    // a narrow timer holds at its largest count
    function automatic logic [TIMER_WIDTH-1:0] reload_value(input logic [TICKS_WIDTH-1:0] t);
        longint unsigned cap;
        cap = (64'd1 << TIMER_WIDTH) - 1;
        if (64'(t) > cap)
            return cap[TIMER_WIDTH-1:0];
        return TIMER_WIDTH'(t);
    endfunction

    function automatic result_t debounce_step(input tick_t t);
        logic    raw;
        logic    sample;
        result_t r;
        sample = 1'b0;
        r = '0;
        if (t.simulate_press)
            raw = 1'b1;
        else if (!t.lid_open && !regs.ignore_lid)
            raw = 1'b0;
        else
            raw = (t.pin_level == regs.active_high);

        if (!started) begin
            // first tick takes the raw level without any edge or pulse
            started = 1'b1;
            debounced = raw;
            last_pin = t.pin_level;
        end else if (t.pin_level != last_pin) begin
            last_pin = t.pin_level;
            if (raw)
                scan_hold = 1'b1;
            countdown = reload_value(regs.debounce_ticks);
            if (countdown == '0) begin
                counting = 1'b0;
                sample = 1'b1;
            end else begin
                counting = 1'b1;
            end
        end else if (counting) begin
            countdown = countdown - TIMER_WIDTH'(1);
            if (countdown == '0) begin
                counting = 1'b0;
                sample = 1'b1;
            end
        end

        if (t.force_evaluate)
            sample = 1'b1;

        if (sample) begin
            if (!raw)
                scan_hold = 1'b0;
            if (raw != debounced) begin
                debounced = raw;
                r.change_pulse = 1'b1;
                r.host_press_pulse = raw;
            end
        end

        r.pressed = debounced;
        r.scan_disabled = scan_hold;
        r.debouncing = counting;
        return r;
    endfunction

    task automatic check_bit(input string name, input logic want, input logic got);
        if (want !== got) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            err_n++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        tick_t   t;
        result_t want;
        result_t got;
        if (!aresetn) begin
            regs.debounce_ticks = DEBOUNCE_TICKS_RESET;
            regs.active_high = 1'b0;
            regs.ignore_lid = 1'b0;
            debounced = 1'b0;
            counting = 1'b0;
            last_pin = 1'b0;
            scan_hold = 1'b0;
            started = 1'b0;
            countdown = '0;
            status_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEBOUNCE_TICKS: regs.debounce_ticks = cfg_data[TICKS_WIDTH-1:0];
                    CFG_ACTIVE_HIGH:    regs.active_high = cfg_data[0];
                    CFG_IGNORE_LID:     regs.ignore_lid = cfg_data[0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                t.pin_level = s_tdata[0];
                t.lid_open = s_tdata[1];
                t.simulate_press = s_tdata[2];
                t.force_evaluate = s_tdata[3];
                status_due.push_back(debounce_step(t));
            end

            if (m_tvalid && m_tready) begin
                got.pressed = m_tdata[0];
                got.scan_disabled = m_tdata[1];
                got.change_pulse = m_tdata[2];
                got.host_press_pulse = m_tdata[3];
                got.debouncing = m_tdata[4];
                if (status_due.size() == 0) begin
                    $error("result beat %0h with no tick outstanding", m_tdata);
                    err_n++;
                end else begin
                    want = status_due.pop_front();
                    check_bit("pressed", want.pressed, got.pressed);
                    check_bit("scan_disabled", want.scan_disabled, got.scan_disabled);
                    check_bit("change_pulse", want.change_pulse, got.change_pulse);
                    check_bit("host_press_pulse", want.host_press_pulse,
                              got.host_press_pulse);
                    check_bit("debouncing", want.debouncing, got.debouncing);
                    if (got.change_pulse)
                        chg_n++;
                    if (got.host_press_pulse)
                        prs_n++;
                end
            end
        end
        errors <= err_n;
        pending <= status_due.size();
        changes <= chg_n;
        presses <= prs_n;
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import pbd_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_TICKS = 85;
    localparam int RANDOM_PHASES = 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNMAPPED = 2'd3;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    // [0] pin_level, [1] lid_open, [2] simulate_press, [3] force_evaluate
    logic [S_TDATA_WIDTH-1:0]   s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    // [0] pressed, [1] scan_disabled, [2] change_pulse, [3] host_press_pulse,
    // [4] debouncing
    logic [M_TDATA_WIDTH-1:0]   m_tdata;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    int  errors;
    int  pending;
    int  changes;
    int  presses;
    int  ticks_sent = 0;
    int  reg_writes = 0;
    int  settings_used = 1;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  calm = 1'b0;

    power_button_debouncer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pbd_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .changes   (changes),
        .presses   (presses)
    );

    always #5 aclk = ~aclk;

    // result side backpressure in bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left <= int'($urandom_range(0, 14));
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_tick(input logic pin, input logic lid, input logic sim,
                             input logic force_ev);
        s_tdata <= S_TDATA_WIDTH'({force_ev, sim, lid, pin});
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        ticks_sent++;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    // stop sending and wait until every tick has its result back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge aclk);
    endtask

    // one-bit registers get random junk in the unused bits
    task automatic program_regs(input logic [TICKS_WIDTH-1:0] ticks, input logic ah,
                                input logic il);
        write_reg(CFG_DEBOUNCE_TICKS, ticks);
        write_reg(CFG_ACTIVE_HIGH, {19'($urandom), ah});
        write_reg(CFG_IGNORE_LID, {19'($urandom), il});
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_UNMAPPED, 20'($urandom));
        settings_used++;
    endtask

    initial begin
        logic [TICKS_WIDTH-1:0] ticks;
        logic                   level;
        logic                   pin;
        int                     bounces;
        int                     hold;
        int                     n;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // power-on defaults: long debounce, active low, lid masks the button
        send_tick(1'b0, 1'b1, 1'b0, 1'b1);  // first tick, force finds no change
        send_tick(1'b1, 1'b1, 1'b0, 1'b0);  // release edge starts the countdown
        send_tick(1'b1, 1'b1, 1'b0, 1'b1);  // forced sample mid countdown
        send_tick(1'b1, 1'b1, 1'b1, 1'b0);  // simulate with no edge
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);  // edge while lid closed
        settle();

        write_reg(CFG_DEBOUNCE_TICKS, 20'hFFFFF);
        write_reg(CFG_ACTIVE_HIGH, 20'h00001);
        write_reg(CFG_IGNORE_LID, 20'h00001);
        write_reg(CFG_UNMAPPED, 20'hFFFFF);
        settings_used++;
        send_tick(1'b1, 1'b0, 1'b0, 1'b0);  // press edge, lid ignored
        send_tick(1'b1, 1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0, 1'b0);
        settle();

        // zero debounce, junk in the upper bits of the flag registers
        write_reg(CFG_DEBOUNCE_TICKS, 20'h00000);
        write_reg(CFG_ACTIVE_HIGH, 20'hFFFFE);
        write_reg(CFG_IGNORE_LID, 20'h00002);
        settings_used++;
        send_tick(1'b1, 1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b1);
        settle();

        write_reg(CFG_DEBOUNCE_TICKS, 20'd3);
        write_reg(CFG_ACTIVE_HIGH, 20'h00001);
        settings_used++;
        repeat (4) send_tick(1'b1, 1'b1, 1'b0, 1'b0);
        repeat (4) send_tick(1'b0, 1'b1, 1'b0, 1'b0);
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: ticks = '0;
                1: ticks = 20'd1;
                2: ticks = 20'hFFFFF;
                3: ticks = 20'($urandom_range(2, 8));
                4: ticks = 20'($urandom_range(0, 40));
                5: ticks = DEBOUNCE_TICKS_RESET;
                6: ticks = 20'($urandom_range(2, 12));
                default: ticks = 20'($urandom_range(1, 6));
            endcase
            if (phase == RANDOM_PHASES - 1)
                calm <= 1'b1;
            program_regs(ticks, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

            n = 0;
            while (n < PHASE_TICKS) begin
                // a press or release: some bounce, then a steady level
                level = 1'($urandom_range(0, 1));
                bounces = int'($urandom_range(0, 4));
                if (ticks > 40)
                    hold = int'($urandom_range(1, 6));
                else
                    hold = int'(ticks) + int'($urandom_range(1, 3));
                for (int k = 0; k < bounces + hold; k++) begin
                    pin = (k < bounces && k % 2 == 0) ? ~level : level;
                    if ($urandom_range(0, 99) < 15)
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    else
                        send_tick(pin, $urandom_range(0, 9) != 0,
                                  $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0);
                    n++;
                    if (phase == 3 && n == PHASE_TICKS / 2)
                        settle();
                end
            end
            settle();
        end

        repeat (10) @(posedge aclk);
        $display("drove %0d ticks under %0d register settings (%0d register writes)",
                 ticks_sent, settings_used, reg_writes);
        $display("observed %0d debounced changes and %0d host press events",
                 changes, presses);
        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
